FILE: rtl/quaternary_neuron_layer_engine_macros.svh
// Assertion macros for the quaternary neuron layer engine
`ifndef QUATERNARY_NEURON_LAYER_ENGINE_MACROS_SVH
`define QUATERNARY_NEURON_LAYER_ENGINE_MACROS_SVH

// Implication checked on every clock edge outside reset
`define QNLE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define QNLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/qnle_pkg.sv
// ----------------------------------------------------------------------------
// qnle_pkg
// Shared types, opcodes and helper functions of the neuron layer engine.
// ----------------------------------------------------------------------------
package qnle_pkg;

    typedef enum logic [1:0] {
        OP_LOAD_INPUT  = 2'd0,
        OP_EVALUATE    = 2'd1,
        OP_UPDATE      = 2'd2,
        OP_LOAD_LATENT = 2'd3
    } t_opcode;

    localparam logic CFG_CLIP_BOUND = 1'b0;
    localparam logic CFG_INPUTS     = 1'b1;

    localparam int unsigned SCORE_W    = 13;
    localparam int unsigned CENTERED_W = 14;
    localparam int unsigned LATENT_W   = 16;
    localparam int unsigned BOUND_W    = 15;
    localparam int unsigned COUNT_W    = 11;
    localparam int unsigned STAT_W     = 13;

    localparam logic [BOUND_W-1:0] BOUND_RESET  = 15'd256;
    localparam logic [COUNT_W-1:0] INPUTS_RESET = 11'd784;
    localparam logic [STAT_W-1:0]  DEV_RESET    = 13'd98;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_WALK,
        ST_DRAIN,
        ST_STATS,
        ST_BANDS,
        ST_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;    // latch the item
        logic clear_acc;  // restart the walk
        logic rd_en;      // read the element under the walk pointer
        logic acc_en;     // fold the element read the cycle before
        logic stats_a;    // mean step
        logic stats_b;    // deviation step and band
        logic finish;     // form the result of the item
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic last_elem;  // walk pointer at the final element
        logic empty_span; // no element to walk
        logic valid_nrn;
        logic valid_el;
    } t_status;

    // Alignment score of input x and weight w, range -3..2
    function automatic logic signed [2:0] align_score(input logic [1:0] x, input logic [1:0] w);
        logic signed [2:0] d;
        begin
            d = $signed({1'b0, x}) - $signed({1'b0, w});
            if (x[1] == w[1]) begin
                align_score = ((x == w) && (x == 2'd0 || x == 2'd3)) ? 3'sd2 : 3'sd1;
            end else begin
                align_score = (d < 0) ? d : -d;
            end
        end
    endfunction

    // Quarter-band quantisation of a clipped latent
    function automatic logic [1:0] band_of(input logic signed [LATENT_W:0] lat,
                                           input logic [BOUND_W-1:0] bound);
        logic signed [LATENT_W:0] half;
        begin
            half = $signed({3'b000, bound[BOUND_W-1:1]});
            if (lat >= half)       band_of = 2'd3;
            else if (lat >= 0)     band_of = 2'd2;
            else if (lat >= -half) band_of = 2'd1;
            else                   band_of = 2'd0;
        end
    endfunction

    // Clip to +/- bound
    function automatic logic signed [LATENT_W:0] clip_latent(input logic signed [LATENT_W:0] v,
                                                           input logic [BOUND_W-1:0] bound);
        logic signed [LATENT_W:0] b;
        begin
            b = $signed({2'b00, bound});
            if (v > b)       clip_latent = b;
            else if (v < -b) clip_latent = -b;
            else             clip_latent = v;
        end
    endfunction

endpackage

FILE: rtl/quaternary_neuron_layer_engine.sv
// Sequence: capture, prime, then for evaluate/update a walk with one
// input/weight/latent read per element and a drain, then the optional stats
// steps and the finish; an empty span skips walk and drain. One item at a
// time: the next item can be taken in the cycle the result shows, unless stalled.
// Reset (synchronous, active low) clears control, config registers and neuron stats;
// input, weight and latent memories stay undefined until written.
// ----------------------------------------------------------------------------
// quaternary_neuron_layer_engine
// Top level: config registers, sequencer and datapath.
// ----------------------------------------------------------------------------
`include "quaternary_neuron_layer_engine_macros.svh"
module quaternary_neuron_layer_engine
    import qnle_pkg::*;
#(
    parameter int MAX_INPUTS  = 1024,
    parameter int MAX_NEURONS = 128,
    parameter int STAT_SHIFT  = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [BOUND_W-1:0]           i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_opcode,
    input  logic [6:0]                   i_neuron,
    input  logic [9:0]                   i_element_index,
    input  logic [1:0]                   i_input_value,
    input  logic                         i_with_stats,
    input  logic                         i_toward_target,
    input  logic signed [LATENT_W-1:0]   i_latent_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_activation,
    output logic signed [SCORE_W-1:0]    o_score,
    output logic signed [CENTERED_W-1:0] o_centered_score
);

    logic [BOUND_W-1:0] r_clip_bound;
    logic [COUNT_W-1:0] r_inputs_in_use;
    t_cmd               cmd;
    t_status            status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_bound    <= BOUND_RESET;
            r_inputs_in_use <= INPUTS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CLIP_BOUND: r_clip_bound    <= i_cfg_data;
                CFG_INPUTS:     r_inputs_in_use <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    qnle_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_opcode(i_opcode), .i_with_stats(i_with_stats),
        .i_status(status), .o_cmd(cmd),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall)
    );

    qnle_datapath #(
        .MAX_INPUTS(MAX_INPUTS), .MAX_NEURONS(MAX_NEURONS), .STAT_SHIFT(STAT_SHIFT)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_clip_bound(r_clip_bound), .i_inputs_in_use(r_inputs_in_use),
        .i_opcode(i_opcode), .i_neuron(i_neuron), .i_element_index(i_element_index),
        .i_input_value(i_input_value), .i_with_stats(i_with_stats),
        .i_toward_target(i_toward_target), .i_latent_value(i_latent_value),
        .o_activation(o_activation), .o_score(o_score),
        .o_centered_score(o_centered_score)
    );

    `QNLE_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, o_out_valid && i_out_stall, o_in_stall, "item accepted while result waits")
    `QNLE_ASSERT_NEXT(a_capture_primes, i_clk, i_rst_n, cmd.capture, cmd.clear_acc, "capture not followed by prime")
    `QNLE_ASSERT_IMPL(a_cmd_excl, i_clk, i_rst_n, cmd.finish, !cmd.rd_en && !cmd.stats_a, "finish overlaps walk")

endmodule

FILE: rtl/qnle_ram.sv
// ----------------------------------------------------------------------------
// qnle_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qnle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/qnle_ctrl.sv
// ----------------------------------------------------------------------------
// qnle_ctrl
// Sequencer: takes one item, walks the elements, runs the stats steps and
// holds the result until it is taken.
// ----------------------------------------------------------------------------
module qnle_ctrl
    import qnle_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [1:0]    i_opcode,
    input  logic          i_with_stats,
    input  t_status       i_status,
    output t_cmd          o_cmd,
    output logic          o_out_valid,
    input  logic          i_out_stall
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   r_walk_op, n_walk_op;
    logic   r_stats, n_stats;
    logic   accept;

    assign o_in_stall  = (r_state != ST_IDLE) || (r_out_valid && i_out_stall);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_walk_op   <= 1'b0;
            r_stats     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_walk_op   <= n_walk_op;
            r_stats     <= n_stats;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_walk_op   = r_walk_op;
        n_stats     = r_stats;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    n_walk_op = (i_opcode == OP_EVALUATE) || (i_opcode == OP_UPDATE);
                    n_stats   = (i_opcode == OP_EVALUATE) && i_with_stats;
                    n_state   = ST_PRIME;
                end
            end
            ST_PRIME: begin
                o_cmd.clear_acc = 1'b1;
                if (r_walk_op && i_status.valid_nrn && !i_status.empty_span) begin
                    n_state = ST_WALK;
                end else if (r_walk_op && i_status.valid_nrn && r_stats) begin
                    // empty span: stats still advance on a zero sum
                    n_state = ST_STATS;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_WALK: begin
                o_cmd.rd_en = 1'b1;
                if (i_status.last_elem) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last read still in flight
                o_cmd.acc_en = 1'b1;
                n_state = r_stats ? ST_STATS : ST_DONE;
            end
            ST_STATS: begin
                o_cmd.stats_a = 1'b1;
                n_state = ST_BANDS;
            end
            ST_BANDS: begin
                o_cmd.stats_b = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                o_cmd.finish = 1'b1;
                n_out_valid  = 1'b1;
                n_state      = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
        if (r_state == ST_WALK) begin
            o_cmd.acc_en = 1'b1;
        end
    end

endmodule

FILE: rtl/qnle_datapath.sv
// ----------------------------------------------------------------------------
// qnle_datapath
// Element walk, alignment accumulation, latent update and running stats.
// ----------------------------------------------------------------------------
module qnle_datapath
    import qnle_pkg::*;
#(
    parameter int MAX_INPUTS  = 1024,
    parameter int MAX_NEURONS = 128,
    parameter int STAT_SHIFT  = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_status                    o_status,
    input  logic [BOUND_W-1:0]         i_clip_bound,
    input  logic [COUNT_W-1:0]         i_inputs_in_use,
    input  logic [1:0]                 i_opcode,
    input  logic [6:0]                 i_neuron,
    input  logic [9:0]                 i_element_index,
    input  logic [1:0]                 i_input_value,
    input  logic                       i_with_stats,
    input  logic                       i_toward_target,
    input  logic signed [LATENT_W-1:0] i_latent_value,
    output logic [1:0]                 o_activation,
    output logic signed [SCORE_W-1:0]  o_score,
    output logic signed [CENTERED_W-1:0] o_centered_score
);

    localparam int EL_W   = $clog2(MAX_INPUTS);
    localparam int NR_W   = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
    localparam int ADDR_W = EL_W + NR_W;
    localparam int SPAN_W = EL_W + 1;
    localparam int ACC_W  = EL_W + 4;

    // captured item
    logic [1:0]                 r_op;
    logic [6:0]                 r_nrn;
    logic [9:0]                 r_el;
    logic [1:0]                 r_ival;
    logic                       r_toward;
    logic signed [LATENT_W-1:0] r_lval;
    logic                       r_stats_en;

    logic [SPAN_W-1:0]          r_ptr;
    logic [SPAN_W-1:0]          r_span;
    logic [EL_W-1:0]            r_p1;
    logic                       r_v1;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SCORE_W-1:0]  r_sum;
    logic signed [CENTERED_W-1:0] r_centered;
    logic [1:0]                 r_act;
    logic [1:0]                 r_act_out;
    logic signed [SCORE_W-1:0]  r_score;
    logic signed [CENTERED_W-1:0] r_cen_out;

    // neuron stats: one valid bit per neuron, unwritten entries read as reset
    logic [MAX_NEURONS-1:0]     r_stat_vld;
    logic [STAT_W-1:0]          mean_rd, dev_rd;
    logic signed [STAT_W-1:0]   mean_cur;
    logic [STAT_W-1:0]          dev_cur;

    logic valid_nrn, valid_el;
    assign valid_nrn = ({25'd0, r_nrn} < 32'(MAX_NEURONS));
    assign valid_el  = ({22'd0, r_el} < 32'(MAX_INPUTS));

    logic [NR_W-1:0] nrn_idx;
    logic [EL_W-1:0] el_idx;
    assign nrn_idx = NR_W'(r_nrn);
    assign el_idx  = EL_W'(r_el);

    // memories
    logic              iv_we, w_we, l_we;
    logic [EL_W-1:0]   iv_waddr;
    logic [1:0]        iv_wdata, iv_rdata, w_rdata, w_wdata;
    logic [ADDR_W-1:0] st_waddr, st_raddr;
    logic signed [LATENT_W-1:0] l_wdata, l_rdata;

    // stats arithmetic
    logic signed [STAT_W+1:0] dm, dm_q, m_next;
    logic signed [STAT_W+1:0] ac, dd, dd_q, dv_next, dlim;

    qnle_ram #(.WIDTH(2), .DEPTH(MAX_INPUTS)) u_input_ram (
        .i_clk(i_clk), .i_we(iv_we), .i_waddr(iv_waddr), .i_wdata(iv_wdata),
        .i_re(i_cmd.rd_en), .i_raddr(r_ptr[EL_W-1:0]), .o_rdata(iv_rdata)
    );
    qnle_ram #(.WIDTH(2), .DEPTH(MAX_INPUTS * MAX_NEURONS)) u_weight_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(st_waddr), .i_wdata(w_wdata),
        .i_re(i_cmd.rd_en), .i_raddr(st_raddr), .o_rdata(w_rdata)
    );
    qnle_ram #(.WIDTH(LATENT_W), .DEPTH(MAX_INPUTS * MAX_NEURONS)) u_latent_ram (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(st_waddr), .i_wdata(l_wdata),
        .i_re(i_cmd.rd_en), .i_raddr(st_raddr), .o_rdata(l_rdata)
    );

    // stats read while priming, held until the next item
    qnle_ram #(.WIDTH(STAT_W), .DEPTH(1 << NR_W)) u_mean_ram (
        .i_clk(i_clk), .i_we(i_cmd.stats_a), .i_waddr(nrn_idx),
        .i_wdata(m_next[STAT_W-1:0]),
        .i_re(i_cmd.clear_acc), .i_raddr(nrn_idx), .o_rdata(mean_rd)
    );
    qnle_ram #(.WIDTH(STAT_W), .DEPTH(1 << NR_W)) u_dev_ram (
        .i_clk(i_clk), .i_we(i_cmd.stats_b), .i_waddr(nrn_idx),
        .i_wdata(dv_next[STAT_W-1:0]),
        .i_re(i_cmd.clear_acc), .i_raddr(nrn_idx), .o_rdata(dev_rd)
    );

    assign mean_cur = r_stat_vld[nrn_idx] ? $signed(mean_rd) : '0;
    assign dev_cur  = r_stat_vld[nrn_idx] ? dev_rd : DEV_RESET;

    assign st_raddr = {nrn_idx, r_ptr[EL_W-1:0]};

    // span saturates at the array size
    logic [SPAN_W-1:0] span_sat;
    always_comb begin
        if ({21'd0, i_inputs_in_use} > 32'(MAX_INPUTS)) span_sat = SPAN_W'(MAX_INPUTS);
        else span_sat = SPAN_W'(i_inputs_in_use);
    end

    // element fold, in the cycle after the read
    logic signed [2:0]          s_al;
    logic signed [3:0]          push;
    logic signed [LATENT_W:0]   lat_new;
    logic signed [LATENT_W:0]   lat_load;
    always_comb begin
        s_al = align_score(iv_rdata, w_rdata);
        push = (s_al < 0) ? -4'(s_al) : 4'(s_al);
        if (!iv_rdata[1]) push = -push;
        if (!r_toward)    push = -push;
        lat_new  = clip_latent(17'(l_rdata) + 17'(push), i_clip_bound);
        lat_load = clip_latent(17'(r_lval), i_clip_bound);
    end

    always_comb begin
        iv_we    = 1'b0;
        iv_waddr = el_idx;
        iv_wdata = r_ival;
        w_we     = 1'b0;
        l_we     = 1'b0;
        st_waddr = {nrn_idx, el_idx};
        l_wdata  = lat_load[LATENT_W-1:0];
        w_wdata  = band_of(lat_load, i_clip_bound);
        if (i_cmd.clear_acc && r_op == OP_LOAD_INPUT && valid_el) begin
            iv_we = 1'b1;
        end
        if (i_cmd.clear_acc && r_op == OP_LOAD_LATENT && valid_el && valid_nrn) begin
            w_we = 1'b1;
            l_we = 1'b1;
        end
        if (i_cmd.acc_en && r_v1 && r_op == OP_UPDATE) begin
            st_waddr = {nrn_idx, r_p1};
            l_wdata  = lat_new[LATENT_W-1:0];
            w_wdata  = band_of(lat_new, i_clip_bound);
            w_we     = 1'b1;
            l_we     = 1'b1;
        end
    end

    assign o_status.last_elem  = (r_ptr == r_span - SPAN_W'(1));
    assign o_status.empty_span = (span_sat == '0);
    assign o_status.valid_nrn  = valid_nrn;
    assign o_status.valid_el   = valid_el;

    // walk pipeline: pointer, read, fold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= i_opcode;
            r_nrn      <= i_neuron;
            r_el       <= i_element_index;
            r_ival     <= i_input_value;
            r_toward   <= i_toward_target;
            r_lval     <= i_latent_value;
            r_stats_en <= i_with_stats;
        end
        if (i_cmd.clear_acc) begin
            r_ptr  <= '0;
            r_span <= span_sat;
            r_acc  <= '0;
        end else begin
            if (i_cmd.rd_en) r_ptr <= r_ptr + SPAN_W'(1);
            if (r_v1) r_acc <= r_acc + ACC_W'(s_al);
        end
        r_p1 <= r_ptr[EL_W-1:0];
    end

    // saturate the sum to the score width
    always_comb begin
        if (r_acc > ACC_W'(4095))       r_sum = 13'sd4095;
        else if (r_acc < -ACC_W'(4096)) r_sum = -13'sd4096;
        else                            r_sum = r_acc[SCORE_W-1:0];
    end

    // stats, mean and deviation steps: truncating division toward zero
    always_comb begin
        dm     = 15'(r_sum) - 15'(mean_cur);
        dm_q   = (dm < 0) ? -((-dm) >>> STAT_SHIFT) : (dm >>> STAT_SHIFT);
        m_next = 15'(mean_cur) + dm_q;
        ac     = (r_centered < 0) ? -15'(r_centered) : 15'(r_centered);
        dd     = ac - $signed({2'b00, dev_cur});
        dd_q   = (dd < 0) ? -((-dd) >>> STAT_SHIFT) : (dd >>> STAT_SHIFT);
        dv_next = $signed({2'b00, dev_cur}) + dd_q;
        dlim   = (dv_next > 1) ? dv_next : 15'sd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stat_vld <= '0;
        end else if (i_cmd.stats_b) begin
            r_stat_vld[nrn_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.stats_a) begin
            r_centered <= 14'(r_sum) - 14'(m_next);
        end
        if (i_cmd.stats_b) begin
            if (15'(r_centered) >= dlim)       r_act <= 2'd3;
            else if (r_centered >= 0)         r_act <= 2'd2;
            else if (15'(r_centered) >= -dlim) r_act <= 2'd1;
            else                              r_act <= 2'd0;
        end
        if (i_cmd.finish) begin
            r_score   <= '0;
            r_cen_out <= '0;
            r_act_out <= 2'd0;
            if (r_op == OP_LOAD_LATENT && valid_nrn && valid_el) begin
                r_act_out <= band_of(lat_load, i_clip_bound);
            end
            if (r_op == OP_EVALUATE && valid_nrn) begin
                r_score <= r_sum;
                if (r_stats_en) begin
                    r_cen_out <= r_centered;
                    r_act_out <= r_act;
                end
            end
        end
    end

    assign o_activation     = r_act_out;
    assign o_score          = r_score;
    assign o_centered_score = r_cen_out;

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quaternary neuron layer engine. Items are
// queued together with the result that a behavioural copy of the layer
// predicts for them, driven with random gaps, and every result taken from
// the block is compared with the oldest prediction. Register settings change
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import qnle_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NEURONS   = 128;
    localparam int ELEMENTS  = 1024;
    localparam int HOLD_SPAN = 100;
    localparam int CYCLE_CAP = 3000000;

    typedef struct {
        t_opcode     op;
        logic [6:0]  neuron;
        logic [9:0]  el;
        logic [1:0]  ival;
        logic        stats;
        logic        toward;
        logic [15:0] lat;
    } t_item;

    typedef struct {
        logic [1:0]  act;
        logic [12:0] score;
        logic [13:0] cent;
    } t_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [14:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_opcode;
    logic [6:0]  i_neuron;
    logic [9:0]  i_element_index;
    logic [1:0]  i_input_value;
    logic        i_with_stats;
    logic        i_toward_target;
    logic signed [15:0] i_latent_value;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_activation;
    logic signed [12:0] o_score;
    logic signed [13:0] o_centered_score;

    quaternary_neuron_layer_engine dut (.*);

    // Behavioural copy of the layer
    logic [1:0] in_vec [ELEMENTS];
    logic [1:0] weight_mem [NEURONS*ELEMENTS];
    int         latent_mem [NEURONS*ELEMENTS];
    int         stat_mean [NEURONS];
    int         run_dev [NEURONS];
    int         clip_lim;
    int         in_use;
    bit         in_written [ELEMENTS];
    bit         lat_written [NEURONS*ELEMENTS];

    t_item pending_items[$];
    t_res  expected_results[$];
    int    mismatches;
    int    cycles;
    bit    no_idle;
    bit    send_paused;
    bit    paused_once;
    bit    start_rx_hold;
    bit    rx_hold_done;
    int    rx_hold_cnt;
    int    tx_gap;
    int    rx_gap;

    function automatic int align(input int x, input int w);
        if ((x >= 2) == (w >= 2)) return (x == w && (x == 0 || x == 3)) ? 2 : 1;
        return (x < w) ? x - w : w - x;
    endfunction

    function automatic logic [1:0] quantise(input int v);
        int half;
        half = clip_lim >> 1;
        if (v >= half) return 2'd3;
        if (v >= 0) return 2'd2;
        if (v >= -half) return 2'd1;
        return 2'd0;
    endfunction

    function automatic int clamp(input int v);
        if (v > clip_lim) return clip_lim;
        if (v < -clip_lim) return -clip_lim;
        return v;
    endfunction

    function automatic t_res predict_layer(input t_item it);
        t_res r;
        int   n, base, sum, m, dv, c, ac, d, v, x, p, k;
        r = '{2'd0, 13'd0, 14'd0};
        n = (in_use > ELEMENTS) ? ELEMENTS : in_use;
        base = int'(it.neuron) * ELEMENTS;
        case (it.op)
            OP_LOAD_INPUT: begin
                in_vec[it.el] = it.ival;
            end
            OP_LOAD_LATENT: begin
                v = clamp(int'($signed(it.lat)));
                latent_mem[base + it.el] = v;
                weight_mem[base + it.el] = quantise(v);
                r.act = weight_mem[base + it.el];
            end
            OP_EVALUATE: begin
                sum = 0;
                for (k = 0; k < n; k++) sum += align(in_vec[k], weight_mem[base + k]);
                if (sum > 4095) sum = 4095;
                if (sum < -4096) sum = -4096;
                r.score = sum[12:0];
                if (it.stats) begin
                    m = stat_mean[it.neuron];
                    m += (sum - m) / 64;
                    stat_mean[it.neuron] = m;
                    c = sum - m;
                    ac = (c < 0) ? -c : c;
                    dv = run_dev[it.neuron];
                    dv += (ac - dv) / 64;
                    run_dev[it.neuron] = dv;
                    d = (dv > 1) ? dv : 1;
                    r.act = (c >= d) ? 2'd3 : (c >= 0) ? 2'd2 : (c >= -d) ? 2'd1 : 2'd0;
                    r.cent = c[13:0];
                end
            end
            default: begin
                for (k = 0; k < n; k++) begin
                    x = in_vec[k];
                    p = align(x, weight_mem[base + k]);
                    if (p < 0) p = -p;
                    if (x < 2) p = -p;
                    if (!it.toward) p = -p;
                    v = clamp(latent_mem[base + k] + p);
                    latent_mem[base + k] = v;
                    weight_mem[base + k] = quantise(v);
                end
            end
        endcase
        return r;
    endfunction

    task automatic queue_item(input t_opcode op, input int nrn, input int el,
                              input int ival, input bit stats, input bit toward,
                              input logic [15:0] lat);
        t_item it;
        it = '{op, nrn[6:0], el[9:0], ival[1:0], stats, toward, lat};
        if (op == OP_LOAD_INPUT) in_written[el] = 1'b1;
        if (op == OP_LOAD_LATENT) lat_written[nrn * ELEMENTS + el] = 1'b1;
        expected_results = {expected_results, predict_layer(it)};
        pending_items = {pending_items, it};
    endtask

    function automatic logic [15:0] random_latent();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return 16'($urandom);
        return 16'($urandom_range(0, 2 * clip_lim + 2) - clip_lim - 1);
    endfunction

    // Make every element the neuron will read valid
    task automatic prepare_neuron(input int nrn);
        int n, k;
        n = (in_use > ELEMENTS) ? ELEMENTS : in_use;
        for (k = 0; k < n; k++) begin
            if (!in_written[k])
                queue_item(OP_LOAD_INPUT, 0, k, $urandom_range(0, 3), 0, 0, 16'd0);
            if (!lat_written[nrn * ELEMENTS + k])
                queue_item(OP_LOAD_LATENT, nrn, k, 0, 0, 0, random_latent());
        end
    endtask

    function automatic bit neuron_ready(input int nrn);
        int n, k;
        n = (in_use > ELEMENTS) ? ELEMENTS : in_use;
        for (k = 0; k < n; k++)
            if (!in_written[k] || !lat_written[nrn * ELEMENTS + k]) return 0;
        return 1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_items.size() != 0 || expected_results.size() != 0 || i_in_valid);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input int value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[14:0];
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_CLIP_BOUND) clip_lim = value & 32'h7FFF;
        else in_use = value & 32'h7FF;
    endtask

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_gap     <= 0;
        end else if (i_in_valid && o_in_stall) begin
            // hold the stalled item
        end else if (tx_gap > 0) begin
            tx_gap     <= tx_gap - 1;
            i_in_valid <= 1'b0;
        end else if (pending_items.size() != 0 && !send_paused) begin
            i_opcode        <= pending_items[0].op;
            i_neuron        <= pending_items[0].neuron;
            i_element_index <= pending_items[0].el;
            i_input_value   <= pending_items[0].ival;
            i_with_stats    <= pending_items[0].stats;
            i_toward_target <= pending_items[0].toward;
            i_latent_value  <= pending_items[0].lat;
            i_in_valid      <= 1'b1;
            void'(pending_items.pop_front());
            tx_gap          <= pick_gap();
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall  <= 1'b0;
            rx_gap       <= 0;
            rx_hold_cnt  <= 0;
            rx_hold_done <= 1'b0;
        end else if (start_rx_hold && !rx_hold_done) begin
            rx_hold_done <= 1'b1;
            rx_hold_cnt  <= 600;
            i_out_stall  <= 1'b1;
        end else if (rx_hold_cnt > 0) begin
            rx_hold_cnt <= rx_hold_cnt - 1;
            i_out_stall <= 1'b1;
        end else if (rx_gap > 0) begin
            rx_gap      <= rx_gap - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            rx_gap      <= pick_gap();
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected: act %0d score %0d centred %0d",
                         $time, o_activation, o_score, o_centered_score);
                mismatches++;
            end else begin
                e = expected_results.pop_front();
                if (o_activation !== e.act) begin
                    $display("%0t: activation expected %0d actual %0d",
                             $time, e.act, o_activation);
                    mismatches++;
                end
                if (o_score !== e.score) begin
                    $display("%0t: score expected %0d actual %0d",
                             $time, $signed(e.score), o_score);
                    mismatches++;
                end
                if (o_centered_score !== e.cent) begin
                    $display("%0t: centred score expected %0d actual %0d",
                             $time, $signed(e.cent), o_centered_score);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("quaternary_neuron_layer_engine test failed");
            $finish;
        end
    end

    initial begin
        int bounds [8];
        int spans [8];
        int ph, k, cnt, nrn, r, j, el;
        logic [15:0] lat_edge [8];
        bounds = '{2, 0, 1, 32767, 256, 5, 1000, 77};
        spans  = '{1, 0, 16, 33, 5, 64, 24, 9};
        lat_edge = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                     16'h0080, 16'h007F, 16'hFF80, 16'hFF7F};
        cycles = 0;
        mismatches = 0;
        no_idle = 1'b0;
        send_paused = 1'b0;
        paused_once = 1'b0;
        start_rx_hold = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_opcode = OP_LOAD_INPUT;
        i_neuron = '0;
        i_element_index = '0;
        i_input_value = '0;
        i_with_stats = 1'b0;
        i_toward_target = 1'b0;
        i_latent_value = '0;
        i_out_stall = 1'b0;
        clip_lim = 256;
        in_use = 784;
        for (k = 0; k < NEURONS; k++) begin
            stat_mean[k] = 0;
            run_dev[k] = 98;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every op, latent extremes, both stats and push modes
        write_reg(CFG_INPUTS, 8);
        for (k = 0; k < 8; k++) queue_item(OP_LOAD_INPUT, 0, k, k % 4, 0, 0, 16'd0);
        for (k = 0; k < 8; k++) queue_item(OP_LOAD_LATENT, 0, k, 0, 0, 0, lat_edge[k]);
        queue_item(OP_EVALUATE, 0, 0, 0, 0, 0, 16'd0);
        queue_item(OP_EVALUATE, 0, 0, 0, 1, 0, 16'd0);
        queue_item(OP_UPDATE, 0, 0, 0, 0, 1, 16'd0);
        queue_item(OP_UPDATE, 0, 0, 0, 0, 0, 16'd0);
        queue_item(OP_EVALUATE, 0, 0, 0, 1, 0, 16'd0);
        queue_item(OP_LOAD_LATENT, 127, 1023, 3, 1, 1, 16'h8000);
        queue_item(OP_LOAD_INPUT, 127, 1023, 3, 1, 1, 16'hFFFF);
        wait_idle();

        // Longer span on one neuron, with a long receiver hold while loads pile up
        write_reg(CFG_INPUTS, HOLD_SPAN);
        write_reg(CFG_CLIP_BOUND, 32767);
        start_rx_hold = 1'b1;
        for (k = 0; k < HOLD_SPAN; k++) begin
            queue_item(OP_LOAD_INPUT, 0, k, $urandom_range(0, 3), 0, 0, 16'd0);
            queue_item(OP_LOAD_LATENT, 127, k, 0, 0, 0, random_latent());
        end
        queue_item(OP_EVALUATE, 127, 0, 0, 1, 0, 16'd0);
        queue_item(OP_UPDATE, 127, 0, 0, 0, 1, 16'd0);
        queue_item(OP_EVALUATE, 127, 0, 0, 1, 0, 16'd0);
        wait_idle();
        queue_item(OP_UPDATE, 127, 0, 0, 0, 0, 16'd0);
        queue_item(OP_EVALUATE, 127, 0, 0, 1, 0, 16'd0);
        queue_item(OP_EVALUATE, 127, 0, 0, 0, 0, 16'd0);
        wait_idle();

        // Random phases over several settings
        for (ph = 0; ph < 8; ph++) begin
            write_reg(CFG_CLIP_BOUND, (ph == 6) ? $urandom_range(2, 32767) : bounds[ph]);
            write_reg(CFG_INPUTS, spans[ph]);
            no_idle = (ph == 4);
            cnt = 0;
            while (cnt < 32) begin
                r = $urandom_range(0, 9);
                nrn = (r < 7) ? $urandom_range(0, 7) : (r < 9) ? 127 : $urandom_range(0, 127);
                j = pending_items.size();
                prepare_neuron(nrn);
                repeat ($urandom_range(3, 9)) begin
                    r = $urandom_range(0, 99);
                    el = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                         : $urandom_range(0, (spans[ph] > 0) ? spans[ph] - 1 : 0);
                    if (r < 35) begin
                        queue_item(OP_EVALUATE, nrn, $urandom_range(0, 1023),
                                   $urandom_range(0, 3), $urandom_range(0, 1),
                                   $urandom_range(0, 1), 16'($urandom));
                    end else if (r < 60) begin
                        queue_item(OP_UPDATE, nrn, $urandom_range(0, 1023),
                                   $urandom_range(0, 3), $urandom_range(0, 1),
                                   $urandom_range(0, 1), 16'($urandom));
                    end else if (r < 80) begin
                        queue_item(OP_LOAD_INPUT, $urandom_range(0, 127), el,
                                   $urandom_range(0, 3), $urandom_range(0, 1),
                                   $urandom_range(0, 1), 16'($urandom));
                    end else begin
                        queue_item(OP_LOAD_LATENT, ($urandom_range(0, 3) == 0) ?
                                   $urandom_range(0, 127) : nrn, el, $urandom_range(0, 3),
                                   $urandom_range(0, 1), $urandom_range(0, 1),
                                   random_latent());
                    end
                    // another neuron when it is already fully loaded
                    k = $urandom_range(0, 7);
                    if ($urandom_range(0, 4) == 0 && neuron_ready(k))
                        queue_item(OP_EVALUATE, k, 0, 0, 1, 0, 16'd0);
                end
                cnt += pending_items.size() - j;
                if (ph == 2 && cnt > 16 && !paused_once) begin
                    // hold the sender until every item in flight has its result
                    paused_once = 1'b1;
                    send_paused = 1'b1;
                    do @(posedge i_clk);
                    while (expected_results.size() != pending_items.size() || i_in_valid);
                    repeat (30) @(posedge i_clk);
                    send_paused = 1'b0;
                end
            end
            wait_idle();
        end
        no_idle = 1'b0;
        repeat (20) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("quaternary_neuron_layer_engine test passed");
        end else begin
            $display("quaternary_neuron_layer_engine test failed");
        end
        $finish;
    end

endmodule
